[hw/rtl/assert_macros.svh]
// Assertion macros for the receiver's top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/dnp3_rx_pkg.sv]
// Types, constants and the CRC-16/DNP step shared by the frame receiver
package dnp3_rx_pkg;

   localparam logic [2:0] KIND_HDR_OK  = 3'd0;
   localparam logic [2:0] KIND_DATA    = 3'd1;
   localparam logic [2:0] KIND_HDR_CRC = 3'd2;
   localparam logic [2:0] KIND_BLK_CRC = 3'd3;
   localparam logic [2:0] KIND_BAD_LEN = 3'd4;

   localparam logic [7:0]  SYNC_FIRST    = 8'h05;
   localparam logic [7:0]  SYNC_SECOND   = 8'h64;
   localparam logic [7:0]  MIN_LENGTH    = 8'd5;
   localparam logic [15:0] CRC_POLY_REFL = 16'hA6BC;

   // block sizes of up to 31 bytes fit this count
   localparam int CNT_W       = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef struct packed {
      logic [7:0]  frame_length;
      logic [7:0]  control_byte;
      logic [15:0] destination;
      logic [15:0] source;
   } hdr_type;

   typedef struct packed {
      logic [2:0]       kind;
      logic [CNT_W-1:0] count;
      logic             fend;
      hdr_type          hdr;
   } cmd_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   localparam logic [15:0] CRC_SYNC = crc_feed(crc_feed(16'h0000, SYNC_FIRST), SYNC_SECOND);

endpackage

[hw/rtl/dnp3_rx_front.sv]
// Front end: sync hunt, header and block CRC checks, pushes commands and data bytes
module dnp3_rx_front #(
   parameter int BLOCK_BYTES = 16,
   parameter int FIFO_AW     = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_byte,
   input  logic                      q_full,
   output logic                      q_push,
   output dnp3_rx_pkg::cmd_type      q_data,
   output logic                      wr_en,
   output logic [FIFO_AW-1:0]        wr_addr,
   output logic [7:0]                wr_data,
   input  logic [FIFO_AW:0]          rd_ptr
);
   import dnp3_rx_pkg::*;

   localparam int PW  = FIFO_AW + 1;
   localparam int BCW = $clog2(BLOCK_BYTES + 1);
   localparam logic [PW-1:0] FIFO_DEPTH = PW'(1 << FIFO_AW);
   localparam logic [7:0]    BLK8       = 8'(BLOCK_BYTES);

   localparam logic [2:0] ST_SYNC1  = 3'd0;
   localparam logic [2:0] ST_SYNC2  = 3'd1;
   localparam logic [2:0] ST_HEADER = 3'd2;
   localparam logic [2:0] ST_DATA   = 3'd3;
   localparam logic [2:0] ST_CRC    = 3'd4;

   logic [2:0]     state_ff, state_in;
   logic [2:0]     hcount_ff, hcount_in;
   logic [7:0]     hdr_ff [6];
   logic [7:0]     hdr_in [6];
   logic [7:0]     left_ff, left_in;
   logic [BCW-1:0] bcount_ff, bcount_in;
   logic [15:0]    crc_ff, crc_in;
   logic [7:0]     low_ff, low_in;
   logic           seen_ff, seen_in;
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;

   logic           accept;
   logic           fifo_full;
   logic [15:0]    crc_next;
   logic [15:0]    got;
   logic [7:0]     blk_size;
   logic [7:0]     bcount8;
   hdr_type        hdr_cur;

   assign fifo_full = (wr_ptr_ff - rd_ptr) == FIFO_DEPTH;
   assign req_ready = !q_full && !fifo_full;
   assign accept    = req_valid && req_ready;
   assign crc_next  = crc_feed(crc_ff, req_byte);
   assign got       = {req_byte, low_ff};
   assign blk_size  = (left_ff > BLK8) ? BLK8 : left_ff;
   assign bcount8   = 8'(bcount_ff);

   assign hdr_cur.frame_length = hdr_ff[0];
   assign hdr_cur.control_byte = hdr_ff[1];
   assign hdr_cur.destination  = {hdr_ff[3], hdr_ff[2]};
   assign hdr_cur.source       = {hdr_ff[5], hdr_ff[4]};

   assign wr_addr = wr_ptr_ff[FIFO_AW-1:0];
   assign wr_data = req_byte;

   always_comb begin
      state_in  = state_ff;
      hcount_in = hcount_ff;
      hdr_in    = hdr_ff;
      left_in   = left_ff;
      bcount_in = bcount_ff;
      crc_in    = crc_ff;
      low_in    = low_ff;
      seen_in   = seen_ff;
      wr_ptr_in = wr_ptr_ff;
      wr_en     = 1'b0;
      q_push    = 1'b0;
      q_data.kind  = KIND_HDR_OK;
      q_data.count = '0;
      q_data.fend  = 1'b0;
      q_data.hdr   = hdr_cur;
      if (accept) begin
         unique case (state_ff)
            ST_SYNC1: begin
               if (req_byte == SYNC_FIRST) state_in = ST_SYNC2;
            end
            ST_SYNC2: begin
               if (req_byte == SYNC_SECOND) begin
                  state_in  = ST_HEADER;
                  hcount_in = '0;
                  crc_in    = CRC_SYNC;
               end else begin
                  state_in = ST_SYNC1;
               end
            end
            ST_HEADER: begin
               if (hcount_ff < 3'd6) begin
                  hdr_in[hcount_ff] = req_byte;
                  crc_in            = crc_next;
               end
               if (hcount_ff == 3'd6) low_in = req_byte;
               hcount_in = hcount_ff + 3'd1;
               if (hcount_ff == 3'd7) begin
                  hcount_in = '0;
                  crc_in    = '0;
                  state_in  = ST_SYNC1;
                  q_push    = 1'b1;
                  if (got != ~crc_ff) begin
                     q_data.kind = KIND_HDR_CRC;
                  end else if (hdr_ff[0] < MIN_LENGTH) begin
                     q_data.kind = KIND_BAD_LEN;
                  end else begin
                     q_data.kind = KIND_HDR_OK;
                     left_in     = hdr_ff[0] - MIN_LENGTH;
                     bcount_in   = '0;
                     seen_in     = 1'b0;
                     if (hdr_ff[0] == MIN_LENGTH) begin
                        q_data.fend = 1'b1;
                     end else begin
                        state_in = ST_DATA;
                     end
                  end
               end
            end
            ST_DATA: begin
               if (bcount_ff < BCW'(BLOCK_BYTES)) begin
                  wr_en     = 1'b1;
                  wr_ptr_in = wr_ptr_ff + PW'(1);
                  bcount_in = bcount_ff + BCW'(1);
               end
               crc_in = crc_next;
               if (8'(bcount_in) >= blk_size) begin
                  state_in = ST_CRC;
                  seen_in  = 1'b0;
               end
            end
            ST_CRC: begin
               if (!seen_ff) begin
                  low_in  = req_byte;
                  seen_in = 1'b1;
               end else begin
                  seen_in      = 1'b0;
                  crc_in       = '0;
                  bcount_in    = '0;
                  q_push       = 1'b1;
                  q_data.count = CNT_W'(bcount_ff);
                  if (got != ~crc_ff || bcount_ff == '0) begin
                     // drop the failed block's bytes from the buffer
                     q_data.kind = KIND_BLK_CRC;
                     wr_ptr_in   = wr_ptr_ff - PW'(bcount_ff);
                     left_in     = '0;
                     state_in    = ST_SYNC1;
                  end else begin
                     q_data.kind = KIND_DATA;
                     q_data.fend = left_ff <= bcount8;
                     left_in     = (left_ff > bcount8) ? left_ff - bcount8 : 8'd0;
                     state_in    = (left_ff > bcount8) ? ST_DATA : ST_SYNC1;
                  end
               end
            end
            default: state_in = ST_SYNC1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_SYNC1;
         hcount_ff <= '0;
         left_ff   <= '0;
         bcount_ff <= '0;
         crc_ff    <= '0;
         low_ff    <= '0;
         seen_ff   <= 1'b0;
         wr_ptr_ff <= '0;
      end else begin
         state_ff  <= state_in;
         hcount_ff <= hcount_in;
         left_ff   <= left_in;
         bcount_ff <= bcount_in;
         crc_ff    <= crc_in;
         low_ff    <= low_in;
         seen_ff   <= seen_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

endmodule

[hw/rtl/dnp3_rx_cmd_queue.sv]
// Short command queue between the front end and the result sequencer
module dnp3_rx_cmd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dnp3_rx_pkg::cmd_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output dnp3_rx_pkg::cmd_type head_data
);
   import dnp3_rx_pkg::*;

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW:0]     rd_ptr_ff, rd_ptr_in;

   assign full       = (wr_ptr_ff - rd_ptr_ff) == (QUEUE_AW + 1)'(QUEUE_DEPTH);
   assign head_valid = wr_ptr_ff != rd_ptr_ff;
   assign head_data  = slot_ff[rd_ptr_ff[QUEUE_AW-1:0]];
   assign wr_ptr_in  = push ? wr_ptr_ff + (QUEUE_AW + 1)'(1) : wr_ptr_ff;
   assign rd_ptr_in  = pop ? rd_ptr_ff + (QUEUE_AW + 1)'(1) : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff[QUEUE_AW-1:0]] <= push_data;
   end

endmodule

[hw/rtl/dnp3_rx_back.sv]
// Back end: byte buffer and result sequencer that expands commands into result words
module dnp3_rx_back #(
   parameter int FIFO_AW = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  dnp3_rx_pkg::cmd_type q_data,
   output logic                 q_pop,
   input  logic                 wr_en,
   input  logic [FIFO_AW-1:0]   wr_addr,
   input  logic [7:0]           wr_data,
   output logic [FIFO_AW:0]     rd_ptr,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_kind,
   output dnp3_rx_pkg::hdr_type rsp_hdr,
   output logic [7:0]           rsp_data,
   output logic                 rsp_last,
   output logic                 rsp_fend
);
   import dnp3_rx_pkg::*;

   localparam int FIFO_DEPTH = 1 << FIFO_AW;

   logic [7:0]         mem [FIFO_DEPTH];
   logic [7:0]         rd_data_ff;
   logic [FIFO_AW:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;

   logic               s1_valid_ff, s1_valid_in;
   logic [2:0]         s1_kind_ff;
   hdr_type            s1_hdr_ff;
   logic               s1_last_ff;
   logic               s1_fend_ff;

   logic               out_valid_ff, out_valid_in;
   logic [2:0]         out_kind_ff;
   hdr_type            out_hdr_ff;
   logic [7:0]         out_data_ff;
   logic               out_last_ff;
   logic               out_fend_ff;

   logic               out_free;
   logic               issue;
   logic               is_blk;
   logic               blk_last;
   logic               item_last;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign issue     = q_valid && (!s1_valid_ff || out_free);
   assign is_blk    = q_data.kind == KIND_DATA;
   assign blk_last  = (idx_ff + CNT_W'(1)) == q_data.count;
   assign item_last = !is_blk || blk_last;
   assign q_pop     = issue && item_last;

   always_comb begin
      rd_ptr_in    = rd_ptr_ff;
      idx_in       = idx_ff;
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (issue && is_blk) begin
         rd_ptr_in = rd_ptr_ff + (FIFO_AW + 1)'(1);
         idx_in    = blk_last ? '0 : idx_ff + CNT_W'(1);
      end
      if (out_free) out_valid_in = s1_valid_ff;
      if (issue) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         idx_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_ptr_ff    <= rd_ptr_in;
         idx_ff       <= idx_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (issue && is_blk) rd_data_ff <= mem[rd_ptr_ff[FIFO_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_kind_ff <= q_data.kind;
         s1_hdr_ff  <= q_data.hdr;
         s1_last_ff <= item_last;
         s1_fend_ff <= item_last && q_data.fend;
      end
      if (out_free && s1_valid_ff) begin
         out_kind_ff <= s1_kind_ff;
         out_hdr_ff  <= s1_hdr_ff;
         out_data_ff <= (s1_kind_ff == KIND_DATA) ? rd_data_ff : 8'h00;
         out_last_ff <= s1_last_ff;
         out_fend_ff <= s1_fend_ff;
      end
   end

   assign rd_ptr    = rd_ptr_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_hdr   = out_hdr_ff;
   assign rsp_data  = out_data_ff;
   assign rsp_last  = out_last_ff;
   assign rsp_fend  = out_fend_ff;

endmodule

[hw/rtl/dnp3_link_frame_receiver.sv]
// DNP3 link-layer frame receiver top level: front end, command queue and back end
//
// The req channel takes one link byte per word (req_tdata[7:0]). The rsp channel
// gives result words: tuser carries the result kind and the frame-end flag, tlast
// marks the last word caused by one input byte, tdata carries the header fields of
// the current frame and, for data words, the verified user byte.
// Throughput: one input byte per cycle unless the queue or the buffer is full,
// and one result word per cycle while the receiver is ready. A good block of n
// bytes leaves as n data words once its second CRC byte is taken. A header or
// block result is queued as a command, then passes the s1 and output registers.
// The front end checks CRCs and parks block bytes in a buffer of 2*BLOCK_BYTES
// entries (rounded up to a power of two); a four-entry command queue feeds the
// back end, which reads the buffer one byte per cycle and fills the output register.
// When the receiver stalls, the output register holds its word; the front end keeps
// taking bytes until the command queue or the byte buffer fills, then drops tready.
// Reset (synchronous) returns the front end to the sync hunt and empties the queue,
// the buffer and the output register. No clearing pass is needed.
module dnp3_link_frame_receiver #(
   parameter int BLOCK_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] frame_length, [15:8] control_byte,
                                    // [31:16] destination, [47:32] source,
                                    // [55:48] data_byte
   output logic [3:0]  rsp_tuser,   // [2:0] kind, [3] frame_end
   output logic        rsp_tlast    // run_last
);
   import dnp3_rx_pkg::*;

   localparam int FIFO_AW = $clog2(2 * BLOCK_BYTES);

   logic               q_push;
   cmd_type            q_push_data;
   logic               q_full;
   logic               q_pop;
   logic               q_valid;
   cmd_type            q_head;
   logic               wr_en;
   logic [FIFO_AW-1:0] wr_addr;
   logic [7:0]         wr_data;
   logic [FIFO_AW:0]   rd_ptr;
   logic [2:0]         rsp_kind;
   hdr_type            rsp_hdr;
   logic [7:0]         rsp_data;
   logic               rsp_fend;

   dnp3_rx_front #(
      .BLOCK_BYTES(BLOCK_BYTES),
      .FIFO_AW(FIFO_AW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_byte(req_tdata),
      .q_full(q_full),
      .q_push(q_push),
      .q_data(q_push_data),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_ptr(rd_ptr)
   );

   dnp3_rx_cmd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_push_data),
      .full(q_full),
      .pop(q_pop),
      .head_valid(q_valid),
      .head_data(q_head)
   );

   dnp3_rx_back #(
      .FIFO_AW(FIFO_AW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_data(q_head),
      .q_pop(q_pop),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_ptr(rd_ptr),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_kind(rsp_kind),
      .rsp_hdr(rsp_hdr),
      .rsp_data(rsp_data),
      .rsp_last(rsp_tlast),
      .rsp_fend(rsp_fend)
   );

   assign rsp_tdata = {rsp_data, rsp_hdr.source, rsp_hdr.destination,
                       rsp_hdr.control_byte, rsp_hdr.frame_length};
   assign rsp_tuser = {rsp_fend, rsp_kind};

`include "assert_macros.svh"

   `ASSERT_IMPLY(a_single_word_last, rsp_tvalid && rsp_kind != KIND_DATA, rsp_tlast,
      "non-data result word without tlast")
   `ASSERT_IMPLY(a_fend_is_last, rsp_tvalid && rsp_fend, rsp_tlast,
      "frame end on a word that is not the last of its byte")
   `ASSERT_IMPLY(a_no_push_when_full, q_push, !q_full, "command pushed into a full queue")
   `ASSERT_NEXT(a_push_shows_head, q_push && !q_pop, q_valid,
      "command queue empty right after a push")

endmodule

[verif/testbench.sv]
// Self-checking testbench for the DNP3 link-layer frame receiver
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dnp3_rx_pkg::*;

   localparam int BLOCK_MAX      = 16;
   localparam int RANDOM_BYTES   = 230;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int MAX_REPORTS    = 100;
   localparam int LAST_HDR_INDEX = 9;

   typedef enum logic [1:0] {
      FLAW_NONE,
      FLAW_HDR_CRC,
      FLAW_BLK_CRC,
      FLAW_SYNC
   } frame_flaw_type;

   typedef enum logic [1:0] {
      FILL_RANDOM,
      FILL_ZEROS,
      FILL_ONES
   } payload_fill_type;

   typedef enum logic [2:0] {
      HUNT_FIRST,
      HUNT_SECOND,
      TAKE_HEADER,
      TAKE_DATA,
      TAKE_CRC
   } link_phase_type;

   typedef struct packed {
      logic [7:0]       len;
      logic [7:0]       ctrl;
      logic [15:0]      dst;
      logic [15:0]      src;
      frame_flaw_type   flaw;
      payload_fill_type fill;
      logic             typed;
      logic [2:0]       want_kind;
      logic             want_fend;
   } frame_spec_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  frame_length;
      logic [7:0]  control_byte;
      logic [15:0] destination;
      logic [15:0] source;
      logic [7:0]  data_byte;
      logic        run_last;
      logic        frame_end;
   } link_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;  // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;          // [7:0] frame_length, [15:8] control_byte,
                                    // [31:16] destination, [47:32] source,
                                    // [55:48] data_byte
   logic [3:0]  rsp_tuser;          // [2:0] kind, [3] frame_end
   logic        rsp_tlast;          // run_last

   dnp3_link_frame_receiver #(
      .BLOCK_BYTES(BLOCK_MAX)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Directed frames; typed rows carry the result of their last header byte.
   frame_spec_type directed_frames [0:11] = '{
      // empty payload; control, destination and source all zero
      '{8'd5,   8'h00, 16'h0000, 16'h0000, FLAW_NONE, FILL_RANDOM, 1'b1, KIND_HDR_OK, 1'b1},
      // longest length, all header bits high, header crc fault
      '{8'd255, 8'hFF, 16'hFFFF, 16'hFFFF, FLAW_HDR_CRC, FILL_ONES, 1'b1, KIND_HDR_CRC, 1'b0},
      // short lengths
      '{8'd0,   8'h3C, 16'h0001, 16'h8000, FLAW_NONE, FILL_RANDOM, 1'b1, KIND_BAD_LEN, 1'b0},
      '{8'd4,   8'h44, 16'hFFFE, 16'h7FFF, FLAW_NONE, FILL_RANDOM, 1'b1, KIND_BAD_LEN, 1'b0},
      // header crc fault
      '{8'd20,  8'hC4, 16'h0400, 16'h0003, FLAW_HDR_CRC, FILL_RANDOM, 1'b1, KIND_HDR_CRC, 1'b0},
      // exactly one full block of zeros
      '{8'd21,  8'h53, 16'hAAAA, 16'h5555, FLAW_NONE, FILL_ZEROS, 1'b1, KIND_HDR_OK, 1'b0},
      // full block plus a one-byte block
      '{8'd22,  8'h73, 16'h0002, 16'h0001, FLAW_NONE, FILL_RANDOM, 1'b0, KIND_HDR_OK, 1'b0},
      // block crc fault
      '{8'd40,  8'h44, 16'h1234, 16'h4321, FLAW_BLK_CRC, FILL_RANDOM, 1'b0, KIND_HDR_OK, 1'b0},
      // second sync byte wrong
      '{8'd10,  8'hC4, 16'h0005, 16'h0064, FLAW_SYNC, FILL_RANDOM, 1'b0, KIND_HDR_OK, 1'b0},
      // two full blocks
      '{8'd37,  8'hF3, 16'h0064, 16'h0005, FLAW_NONE, FILL_RANDOM, 1'b0, KIND_HDR_OK, 1'b0},
      '{8'd6,   8'h80, 16'hFFFF, 16'h0000, FLAW_NONE, FILL_ONES, 1'b0, KIND_HDR_OK, 1'b0},
      '{8'd5,   8'hFF, 16'h0000, 16'hFFFF, FLAW_HDR_CRC, FILL_RANDOM, 1'b1, KIND_HDR_CRC, 1'b0}
   };

   // receiver state mirror
   link_phase_type link_phase;
   logic [7:0]     hdr_store [0:7];
   logic [3:0]     hdr_count;
   logic [7:0]     payload_left;
   logic [4:0]     blk_count;
   logic [7:0]     blk_store [0:15];
   logic [15:0]    crc_acc;
   logic [7:0]     crc_low;
   logic           crc_seen;

   link_result_type byte_results [$];
   link_result_type expected_results [$];
   int              fail_count = 0;
   int              frame_bytes_sent = 0;
   int              burst_left = 1;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] dnp_crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ b[i];
         c = c >> 1;
         if (fb) begin
            c = c ^ CRC_POLY_REFL;
         end
      end
      return c;
   endfunction

   function automatic link_result_type frame_result(input logic [2:0] kind,
                                                    input logic [7:0] data,
                                                    input logic last, input logic fend);
      link_result_type r;
      r.kind         = kind;
      r.frame_length = hdr_store[0];
      r.control_byte = hdr_store[1];
      r.destination  = {hdr_store[3], hdr_store[2]};
      r.source       = {hdr_store[5], hdr_store[4]};
      r.data_byte    = data;
      r.run_last     = last;
      r.frame_end    = fend;
      return r;
   endfunction

   // Advance the mirror by one byte; results land in byte_results.
   function automatic void predict_link_byte(input logic [7:0] b);
      logic [15:0] got;
      logic [15:0] want;
      int          take;
      int          n;
      byte_results.delete();
      case (link_phase)
         HUNT_FIRST: begin
            if (b == SYNC_FIRST) link_phase = HUNT_SECOND;
         end
         HUNT_SECOND: begin
            if (b == SYNC_SECOND) begin
               link_phase = TAKE_HEADER;
               hdr_count = 4'd0;
               crc_acc = dnp_crc_step(dnp_crc_step(16'h0000, SYNC_FIRST), SYNC_SECOND);
            end else begin
               link_phase = HUNT_FIRST;
            end
         end
         TAKE_HEADER: begin
            hdr_store[hdr_count[2:0]] = b;
            if (hdr_count < 4'd6) crc_acc = dnp_crc_step(crc_acc, b);
            hdr_count = hdr_count + 4'd1;
            if (hdr_count >= 4'd8) begin
               hdr_count = 4'd0;
               got = {hdr_store[7], hdr_store[6]};
               want = ~crc_acc;
               crc_acc = 16'h0000;
               link_phase = HUNT_FIRST;
               if (got != want) begin
                  byte_results.push_back(frame_result(KIND_HDR_CRC, 8'h00, 1'b1, 1'b0));
               end else if (hdr_store[0] < MIN_LENGTH) begin
                  byte_results.push_back(frame_result(KIND_BAD_LEN, 8'h00, 1'b1, 1'b0));
               end else begin
                  payload_left = hdr_store[0] - MIN_LENGTH;
                  blk_count = 5'd0;
                  crc_seen = 1'b0;
                  if (payload_left == 8'd0) begin
                     byte_results.push_back(frame_result(KIND_HDR_OK, 8'h00, 1'b1, 1'b1));
                  end else begin
                     link_phase = TAKE_DATA;
                     byte_results.push_back(frame_result(KIND_HDR_OK, 8'h00, 1'b1, 1'b0));
                  end
               end
            end
         end
         TAKE_DATA: begin
            if (blk_count < BLOCK_MAX) begin
               blk_store[blk_count[3:0]] = b;
               blk_count = blk_count + 5'd1;
            end
            crc_acc = dnp_crc_step(crc_acc, b);
            take = (payload_left > BLOCK_MAX) ? BLOCK_MAX : int'(payload_left);
            if (int'(blk_count) >= take) begin
               link_phase = TAKE_CRC;
               crc_seen = 1'b0;
            end
         end
         TAKE_CRC: begin
            if (!crc_seen) begin
               crc_low = b;
               crc_seen = 1'b1;
            end else begin
               crc_seen = 1'b0;
               got = {b, crc_low};
               want = ~crc_acc;
               crc_acc = 16'h0000;
               n = int'(blk_count);
               blk_count = 5'd0;
               if (got != want || n == 0) begin
                  link_phase = HUNT_FIRST;
                  payload_left = 8'd0;
                  byte_results.push_back(frame_result(KIND_BLK_CRC, 8'h00, 1'b1, 1'b0));
               end else begin
                  payload_left = (int'(payload_left) > n) ? payload_left - 8'(n) : 8'd0;
                  link_phase = (payload_left == 8'd0) ? HUNT_FIRST : TAKE_DATA;
                  for (int i = 0; i < n; i++) begin
                     byte_results.push_back(frame_result(KIND_DATA, blk_store[i], i == n - 1,
                                                         i == n - 1 && payload_left == 8'd0));
                  end
               end
            end
         end
         default: link_phase = HUNT_FIRST;
      endcase
   endfunction

   // Offer one byte, hold it until taken, update the expectations, then sometimes idle the channel.
   task automatic push_byte(input logic [7:0] b, input logic use_typed,
                            input link_result_type typed_result);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_link_byte(b);
      if (use_typed) begin
         expected_results.push_back(typed_result);
      end else begin
         foreach (byte_results[i]) expected_results.push_back(byte_results[i]);
      end
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 12);
      end
   endtask

   function automatic logic [7:0] fill_byte(input payload_fill_type fill);
      case (fill)
         FILL_ZEROS: return 8'h00;
         FILL_ONES:  return 8'hFF;
         default:    return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_frame(input frame_spec_type spec);
      logic [7:0]      wire_bytes [$];
      logic [7:0]      d;
      logic [15:0]     crc;
      link_result_type header_want;
      int              left;
      int              take;
      int              blk;
      int              bad_block;
      header_want = '{spec.want_kind, spec.len, spec.ctrl, spec.dst, spec.src,
                      8'h00, 1'b1, spec.want_fend};
      wire_bytes.push_back(SYNC_FIRST);
      if (spec.flaw == FLAW_SYNC) begin
         d = ($urandom_range(0, 1) == 0) ? SYNC_FIRST : 8'($urandom_range(0, 255));
         wire_bytes.push_back(d == SYNC_SECOND ? SYNC_FIRST : d);
      end else begin
         wire_bytes.push_back(SYNC_SECOND);
      end
      wire_bytes.push_back(spec.len);
      wire_bytes.push_back(spec.ctrl);
      wire_bytes.push_back(spec.dst[7:0]);
      wire_bytes.push_back(spec.dst[15:8]);
      wire_bytes.push_back(spec.src[7:0]);
      wire_bytes.push_back(spec.src[15:8]);
      crc = dnp_crc_step(dnp_crc_step(16'h0000, SYNC_FIRST), SYNC_SECOND);
      for (int i = 2; i < 8; i++) crc = dnp_crc_step(crc, wire_bytes[i]);
      crc = ~crc;
      if (spec.flaw == FLAW_HDR_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      wire_bytes.push_back(crc[7:0]);
      wire_bytes.push_back(crc[15:8]);

      // a rejected header ends the frame
      left = (spec.len >= MIN_LENGTH && spec.flaw != FLAW_HDR_CRC)
             ? int'(spec.len - MIN_LENGTH) : 0;
      bad_block = (spec.flaw == FLAW_BLK_CRC && left > 0)
                  ? $urandom_range(0, (left + BLOCK_MAX - 1) / BLOCK_MAX - 1) : -1;
      blk = 0;
      while (left > 0) begin
         take = (left > BLOCK_MAX) ? BLOCK_MAX : left;
         crc = 16'h0000;
         for (int j = 0; j < take; j++) begin
            d = fill_byte(spec.fill);
            wire_bytes.push_back(d);
            crc = dnp_crc_step(crc, d);
         end
         crc = ~crc;
         if (blk == bad_block) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
         wire_bytes.push_back(crc[7:0]);
         wire_bytes.push_back(crc[15:8]);
         // drop the rest of the frame after a corrupted block
         if (blk == bad_block) break;
         left -= take;
         blk++;
      end

      foreach (wire_bytes[i]) begin
         push_byte(wire_bytes[i],
                   spec.typed && spec.flaw != FLAW_SYNC && i == LAST_HDR_INDEX,
                   header_want);
         frame_bytes_sent++;
      end
   endtask

   task automatic send_noise();
      link_result_type unused;
      int              n;
      unused = '0;
      n = $urandom_range(1, 6);
      repeat (n) begin
         push_byte(($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom_range(0, 255)),
                   1'b0, unused);
      end
   endtask

   function automatic void check_field(input string field, input logic [15:0] want_v,
                                       input logic [15:0] got_v);
      if (want_v !== got_v) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want_v, got_v);
         end
      end
   endfunction

   always @(posedge clock) begin
      link_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("%0t: unexpected word: expected none, actual tdata %h tuser %h tlast %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
            end
         end else begin
            want = expected_results.pop_front();
            check_field("kind",         16'(want.kind),         16'(rsp_tuser[2:0]));
            check_field("frame_length", 16'(want.frame_length), 16'(rsp_tdata[7:0]));
            check_field("control_byte", 16'(want.control_byte), 16'(rsp_tdata[15:8]));
            check_field("destination",  want.destination,       rsp_tdata[31:16]);
            check_field("source",       want.source,            rsp_tdata[47:32]);
            check_field("data_byte",    16'(want.data_byte),    16'(rsp_tdata[55:48]));
            check_field("run_last",     16'(want.run_last),     16'(rsp_tlast));
            check_field("frame_end",    16'(want.frame_end),    16'(rsp_tuser[3]));
         end
      end
   end

   // Receiver stalls: spans of always-ready, light, heavy and periodic stalling.
   initial begin : rsp_stall_pattern
      int mode;
      int span;
      int tick;
      tick = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 120);
         repeat (span) begin
            @(posedge clock);
            tick++;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               2:       rsp_tready <= ($urandom_range(0, 9) < 3);
               default: rsp_tready <= ((tick % 8) < 5);
            endcase
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("testbench: FAIL");
      $finish;
   end

   initial begin : stimulus
      frame_spec_type spec;
      int             pick;
      link_phase   = HUNT_FIRST;
      hdr_count    = 4'd0;
      payload_left = 8'd0;
      blk_count    = 5'd0;
      crc_acc      = 16'h0000;
      crc_low      = 8'h00;
      crc_seen     = 1'b0;
      for (int i = 0; i < 8; i++) hdr_store[i] = 8'h00;
      for (int i = 0; i < BLOCK_MAX; i++) blk_store[i] = 8'h00;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_frames[i]) send_frame(directed_frames[i]);

      frame_bytes_sent = 0;
      while (frame_bytes_sent < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_noise();
         end else begin
            spec.ctrl      = 8'($urandom_range(0, 255));
            spec.dst       = 16'($urandom_range(0, 65535));
            spec.src       = 16'($urandom_range(0, 65535));
            spec.fill      = ($urandom_range(0, 9) != 0) ? FILL_RANDOM
                             : (($urandom_range(0, 1) == 0) ? FILL_ZEROS : FILL_ONES);
            spec.typed     = 1'b0;
            spec.want_kind = KIND_HDR_OK;
            spec.want_fend = 1'b0;
            if (pick < 68)      spec.flaw = FLAW_NONE;
            else if (pick < 78) spec.flaw = FLAW_HDR_CRC;
            else if (pick < 86) spec.flaw = FLAW_BLK_CRC;
            else if (pick < 93) spec.flaw = FLAW_NONE;
            else                spec.flaw = FLAW_SYNC;
            if (pick >= 86 && pick < 93) begin
               spec.len = 8'($urandom_range(0, 4));
            end else if ($urandom_range(0, 11) == 0) begin
               spec.len = 8'($urandom_range(60, 255));
            end else begin
               spec.len = 8'($urandom_range(5, 45));
            end
            send_frame(spec);
         end
      end
      if (req_tvalid) req_tvalid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
